[design/sorted_key_child_table_assert.svh]
// Assertion macros for the sorted key and child table.
`ifndef SORTED_KEY_CHILD_TABLE_ASSERT_SVH
`define SORTED_KEY_CHILD_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SKCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SKCT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/skct_pkg.sv]
// Types and codes shared by the sorted key and child table.
package skct_pkg;

    typedef enum logic [2:0] {
        ACT_LOOKUP    = 3'd0,
        ACT_INSERT    = 3'd1,
        ACT_REMOVE    = 3'd2,
        ACT_SET_KEY   = 3'd3,
        ACT_SET_CHILD = 3'd4,
        ACT_READ      = 3'd5,
        ACT_CLEAR     = 3'd6
    } act_t;

    typedef enum logic [2:0] {
        STS_OK     = 3'd0,
        STS_RANGE  = 3'd1,
        STS_ANCHOR = 3'd2,
        STS_FULL   = 3'd3,
        STS_EMPTY  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_FIND,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_PLACE,
        S_READ,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] search_key;
        logic [7:0]  slot;
        logic [31:0] anchor_child;
        logic [31:0] child_ptr;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_child;
        logic [31:0] found_key;
        logic [8:0]  entry_count;
    } rsp_t;

endpackage

[design/sorted_key_child_table.sv]
// Sorted key and child table: one internal node of a B+ tree held in two memories.
//
// An ordered table of up to CAPACITY (key, child) pairs kept in two
// single-port-read, single-port-write memories with registered reads.
// One request is worked at a time and gives exactly one response.  Lookup
// returns the child of the first entry whose key is not below the search key,
// or the last child when every key is smaller.  Insert places the pair right
// after the first entry holding anchor_child (an empty table takes the pair at
// entry 0 whatever the anchor).  Remove, set_key, set_child and read act on
// slot; clear empties the table.  The memory port is walked one entry per
// cycle; for insert, the anchor scan and the upward shift together walk n
// entries, with n the entry count, then one more step places the pair.
// Any request may also wait for the response register to drain.
// A new request is taken once the previous one has been placed in the response
// register, so it may overlap a response still stalled.
// The memories come out of reset undefined; only entries below the count are
// ever read for a result, so no clearing pass is needed.  Keys are KEY_BITS
// wide: search_key is truncated or zero-extended to that width and found_key
// carries its low 32 bits.
module sorted_key_child_table #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  skct_pkg::req_t  req_data,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output skct_pkg::rsp_t  rsp_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = CNT_W + 8;

    // Entry memories
    logic [KEY_BITS-1:0] key_mem   [CAPACITY];
    logic [31:0]         child_mem [CAPACITY];

    skct_pkg::state_t    state_reg, state_next;
    skct_pkg::req_t      op_reg, op_next;
    skct_pkg::rsp_t      res_reg, res_next;
    skct_pkg::rsp_t      rsp_reg, rsp_next;
    logic                rsp_vld_reg, rsp_vld_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;      // next read address of a walk
    logic [IDX_W-1:0]    pos_reg, pos_next;      // insert position
    logic [IDX_W-1:0]    rd_idx_reg;             // address behind key_q / child_q

    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic                key_we, child_we;
    logic [KEY_BITS-1:0] wr_key;
    logic [31:0]         wr_child;
    logic [KEY_BITS-1:0] key_q;
    logic [31:0]         child_q;

    logic [KEY_BITS-1:0] key_in;
    logic [IDX_W-1:0]    last_idx;
    logic [IDX_W-1:0]    slot_idx;
    logic                slot_ok;
    logic [2:0]          slot_sts;
    logic                out_free;

    assign key_in    = KEY_BITS'(64'(op_reg.search_key));
    assign last_idx  = IDX_W'(fill_reg - CNT_W'(1));
    assign slot_idx  = IDX_W'(op_reg.slot);
    assign slot_ok   = (fill_reg != '0) && (CMP_W'(op_reg.slot) < CMP_W'(fill_reg));
    assign slot_sts  = (fill_reg == '0) ? skct_pkg::STS_EMPTY : skct_pkg::STS_RANGE;
    assign out_free  = !rsp_vld_reg || !rsp_stall;

    assign req_stall = (state_reg != skct_pkg::S_IDLE);
    assign rsp_valid = rsp_vld_reg;
    assign rsp_data  = rsp_reg;

    // Memories: registered read, one write port each
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (child_we)
        begin
            child_mem[wr_addr] <= wr_child;
        end
        key_q      <= key_mem[rd_addr];
        child_q    <= child_mem[rd_addr];
        rd_idx_reg <= rd_addr;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= skct_pkg::S_IDLE;
            fill_reg    <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
        ptr_reg <= ptr_next;
        pos_reg <= pos_next;
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        res_next     = res_reg;
        rsp_next     = rsp_reg;
        rsp_vld_next = rsp_vld_reg && rsp_stall;
        fill_next    = fill_reg;
        ptr_next     = ptr_reg;
        pos_next     = pos_reg;
        rd_addr      = ptr_reg;
        wr_addr      = pos_reg;
        key_we       = 1'b0;
        child_we     = 1'b0;
        wr_key       = key_in;
        wr_child     = op_reg.child_ptr;

        case (state_reg)
            skct_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req_data;
                    state_next = skct_pkg::S_START;
                end
            end

            skct_pkg::S_START:
            begin
                res_next   = '{status: skct_pkg::STS_OK, found_child: '0,
                               found_key: '0, entry_count: '0};
                state_next = skct_pkg::S_RESULT;
                case (op_reg.action)
                    skct_pkg::ACT_LOOKUP:
                    begin
                        if (fill_reg == '0)
                        begin
                            res_next.status = skct_pkg::STS_EMPTY;
                        end
                        else
                        begin
                            rd_addr    = '0;
                            ptr_next   = IDX_W'(1);
                            state_next = skct_pkg::S_FIND;
                        end
                    end
                    skct_pkg::ACT_INSERT:
                    begin
                        if (fill_reg == CNT_W'(CAPACITY))
                        begin
                            res_next.status = skct_pkg::STS_FULL;
                        end
                        else if (fill_reg == '0)
                        begin
                            wr_addr   = '0;
                            key_we    = 1'b1;
                            child_we  = 1'b1;
                            fill_next = CNT_W'(1);
                        end
                        else
                        begin
                            rd_addr    = '0;
                            ptr_next   = IDX_W'(1);
                            state_next = skct_pkg::S_FIND;
                        end
                    end
                    skct_pkg::ACT_REMOVE:
                    begin
                        if (!slot_ok)
                        begin
                            res_next.status = slot_sts;
                        end
                        else if (slot_idx == last_idx)
                        begin
                            fill_next = fill_reg - CNT_W'(1);
                        end
                        else
                        begin
                            rd_addr    = slot_idx + IDX_W'(1);
                            ptr_next   = slot_idx + IDX_W'(2);
                            state_next = skct_pkg::S_SHIFT_DN;
                        end
                    end
                    skct_pkg::ACT_SET_KEY:
                    begin
                        if (!slot_ok)
                        begin
                            res_next.status = slot_sts;
                        end
                        else
                        begin
                            wr_addr = slot_idx;
                            key_we  = 1'b1;
                        end
                    end
                    skct_pkg::ACT_SET_CHILD:
                    begin
                        if (!slot_ok)
                        begin
                            res_next.status = slot_sts;
                        end
                        else
                        begin
                            wr_addr  = slot_idx;
                            child_we = 1'b1;
                        end
                    end
                    skct_pkg::ACT_READ:
                    begin
                        if (!slot_ok)
                        begin
                            res_next.status = slot_sts;
                        end
                        else
                        begin
                            rd_addr    = slot_idx;
                            state_next = skct_pkg::S_READ;
                        end
                    end
                    skct_pkg::ACT_CLEAR:
                    begin
                        fill_next = '0;
                    end
                    default:
                    begin
                        res_next.status = skct_pkg::STS_OK;
                    end
                endcase
            end

            // Forward walk: lookup key compare or insert anchor search
            skct_pkg::S_FIND:
            begin
                ptr_next = ptr_reg + IDX_W'(1);
                if (op_reg.action == skct_pkg::ACT_LOOKUP)
                begin
                    if (!(key_q < key_in) || (rd_idx_reg == last_idx))
                    begin
                        res_next.found_child = child_q;
                        state_next           = skct_pkg::S_RESULT;
                    end
                end
                else if (child_q == op_reg.anchor_child)
                begin
                    pos_next = rd_idx_reg + IDX_W'(1);
                    if (rd_idx_reg == last_idx)
                    begin
                        state_next = skct_pkg::S_PLACE;
                    end
                    else
                    begin
                        // open the gap from the top entry downwards
                        rd_addr    = last_idx;
                        ptr_next   = last_idx - IDX_W'(1);
                        state_next = skct_pkg::S_SHIFT_UP;
                    end
                end
                else if (rd_idx_reg == last_idx)
                begin
                    res_next.status = skct_pkg::STS_ANCHOR;
                    state_next      = skct_pkg::S_RESULT;
                end
            end

            // entry i moves to i+1; the write trails the read by one entry
            skct_pkg::S_SHIFT_UP:
            begin
                ptr_next = ptr_reg - IDX_W'(1);
                wr_addr  = rd_idx_reg + IDX_W'(1);
                wr_key   = key_q;
                wr_child = child_q;
                key_we   = 1'b1;
                child_we = 1'b1;
                if (rd_idx_reg == pos_reg)
                begin
                    state_next = skct_pkg::S_PLACE;
                end
            end

            // entry i moves to i-1
            skct_pkg::S_SHIFT_DN:
            begin
                ptr_next = ptr_reg + IDX_W'(1);
                wr_addr  = rd_idx_reg - IDX_W'(1);
                wr_key   = key_q;
                wr_child = child_q;
                key_we   = 1'b1;
                child_we = 1'b1;
                if (rd_idx_reg == last_idx)
                begin
                    fill_next  = fill_reg - CNT_W'(1);
                    state_next = skct_pkg::S_RESULT;
                end
            end

            skct_pkg::S_PLACE:
            begin
                wr_addr    = pos_reg;
                key_we     = 1'b1;
                child_we   = 1'b1;
                fill_next  = fill_reg + CNT_W'(1);
                state_next = skct_pkg::S_RESULT;
            end

            skct_pkg::S_READ:
            begin
                res_next.found_child = child_q;
                res_next.found_key   = 32'(64'(key_q));
                state_next           = skct_pkg::S_RESULT;
            end

            // hand over once the response register is free
            skct_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    rsp_next             = res_reg;
                    rsp_next.entry_count = 9'(fill_reg);
                    rsp_vld_next         = 1'b1;
                    state_next           = skct_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = skct_pkg::S_IDLE;
            end
        endcase
    end

`include "sorted_key_child_table_assert.svh"

    // count moves by one per request, or drops to zero on clear
    `SKCT_ASSERT_IMP(a_fill_step, fill_reg != $past(fill_reg),
        (fill_reg == '0) || (fill_reg == CNT_W'($past(fill_reg) + CNT_W'(1)))
            || (fill_reg == CNT_W'($past(fill_reg) - CNT_W'(1))),
        "entry count jumped")
    // full is only reported at capacity
    `SKCT_ASSERT_IMP(a_full_sts,
        (state_reg == skct_pkg::S_RESULT) && out_free
            && (res_reg.status == skct_pkg::STS_FULL),
        fill_reg == CNT_W'(CAPACITY), "full reported below capacity")
    // response carries the count left by its request
    `SKCT_ASSERT_NXT(a_rsp_count, (state_reg == skct_pkg::S_RESULT) && out_free,
        rsp_valid && (rsp_data.entry_count == 9'(fill_reg)), "response count mismatch")

endmodule

[sim/skct_tb_pkg.sv]
// Scoreboard for the sorted key and child table: a table predictor and a response check.
`timescale 1ns / 1ps

package skct_tb_pkg;

    import skct_pkg::*;

    localparam int TABLE_DEPTH = 256;

    class table_scoreboard;

        // Predicted contents of the node
        logic [31:0] keys [TABLE_DEPTH];
        logic [31:0] kids [TABLE_DEPTH];
        int unsigned fill;

        rsp_t        awaited_q [$];
        int unsigned errors;
        int unsigned accepted;
        int unsigned checked;
        int unsigned peak_fill;
        int unsigned status_seen [8];

        function new();
            fill = 0;
            errors = 0;
            accepted = 0;
            checked = 0;
            peak_fill = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function status_t slot_check(int unsigned idx);
            if (fill == 0)
                return STS_EMPTY;
            if (idx >= fill)
                return STS_RANGE;
            return STS_OK;
        endfunction

        // Works one request against the predicted table.
        function rsp_t apply_request(req_t r);
            rsp_t        o;
            status_t     st;
            int unsigned i;
            int unsigned pos;
            o = '0;
            st = STS_OK;
            case (r.action)
                ACT_LOOKUP:
                begin
                    if (fill == 0)
                        st = STS_EMPTY;
                    else
                    begin
                        i = 0;
                        while (i + 1 < fill && keys[i] < r.search_key)
                            i++;
                        o.found_child = kids[i];
                    end
                end
                ACT_INSERT:
                begin
                    if (fill >= TABLE_DEPTH)
                        st = STS_FULL;
                    else
                    begin
                        pos = 0;
                        if (fill != 0)
                        begin
                            i = 0;
                            while (i < fill && kids[i] !== r.anchor_child)
                                i++;
                            if (i == fill)
                                st = STS_ANCHOR;
                            pos = i + 1;
                        end
                        if (st == STS_OK)
                        begin
                            for (i = fill; i > pos; i--)
                            begin
                                keys[i] = keys[i - 1];
                                kids[i] = kids[i - 1];
                            end
                            keys[pos] = r.search_key;
                            kids[pos] = r.child_ptr;
                            fill++;
                        end
                    end
                end
                ACT_REMOVE:
                begin
                    st = slot_check(r.slot);
                    if (st == STS_OK)
                    begin
                        for (i = r.slot; i + 1 < fill; i++)
                        begin
                            keys[i] = keys[i + 1];
                            kids[i] = kids[i + 1];
                        end
                        fill--;
                    end
                end
                ACT_SET_KEY:
                begin
                    st = slot_check(r.slot);
                    if (st == STS_OK)
                        keys[r.slot] = r.search_key;
                end
                ACT_SET_CHILD:
                begin
                    st = slot_check(r.slot);
                    if (st == STS_OK)
                        kids[r.slot] = r.child_ptr;
                end
                ACT_READ:
                begin
                    st = slot_check(r.slot);
                    if (st == STS_OK)
                    begin
                        o.found_child = kids[r.slot];
                        o.found_key = keys[r.slot];
                    end
                end
                ACT_CLEAR:
                    fill = 0;
                default:
                    ;
            endcase
            if (fill > peak_fill)
                peak_fill = fill;
            o.status = st;
            o.entry_count = fill[8:0];
            return o;
        endfunction

        function void note_request(req_t r);
            awaited_q.push_back(apply_request(r));
            accepted++;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_response(rsp_t got);
            rsp_t want;
            if (awaited_q.size() == 0)
            begin
                report($sformatf("response with nothing awaited: %h", got));
                return;
            end
            want = awaited_q.pop_front();
            checked++;
            status_seen[want.status]++;
            if (got.status !== want.status)
                report($sformatf("response %0d status %0d, want %0d",
                                 checked, got.status, want.status));
            if (got.found_child !== want.found_child)
                report($sformatf("response %0d found_child %h, want %h",
                                 checked, got.found_child, want.found_child));
            if (got.found_key !== want.found_key)
                report($sformatf("response %0d found_key %h, want %h",
                                 checked, got.found_key, want.found_key));
            if (got.entry_count !== want.entry_count)
                report($sformatf("response %0d entry_count %0d, want %0d",
                                 checked, got.entry_count, want.entry_count));
        endtask

    endclass

endpackage

[sim/tb_sorted_key_child_table.sv]
// Self-checking bench for the sorted key and child table.
`timescale 1ns / 1ps

module tb_sorted_key_child_table;

    import skct_pkg::*;
    import skct_tb_pkg::*;

    // Action code left unused by the block: must come back as a no-op
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    localparam int RAND_PER_PHASE = 240;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_GAP        = 60;
    // Worst single request is an insert into a nearly full table
    localparam int DRAIN_CYCLES   = 2 * TABLE_DEPTH + 8;
    localparam int MAX_CYCLES     = 3_000_000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    table_scoreboard sb;

    // Idling knobs, percent of cycles, changed between phases
    int unsigned send_idle_pct  = 0;
    int unsigned stall_pct      = 0;

    // Long receiver hold-off: main kicks it, the receiver counts it down
    bit          hold_kick      = 1'b0;
    int unsigned hold_left      = 0;

    int unsigned cycle_count    = 0;

    sorted_key_child_table #(
        .CAPACITY(TABLE_DEPTH),
        .KEY_BITS(32)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: the whole run must finish well inside this
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Response side. Values seen here are those from before the edge, so a
    // response counts as taken exactly when the block saw rsp_stall low.
    // The stall for the next cycle is chosen afterwards, one assignment per edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp_data);
            if (hold_kick)
            begin
                hold_left = HOLD_CYCLES;
                hold_kick = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // Offers one request, after a random idle gap, and holds it until taken.
    // valid is written at most once per edge: lowered only when a gap follows.
    task automatic send_request(input req_t r);
        int unsigned gap;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < MAX_GAP)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic send_fields(input logic [2:0] act, input logic [31:0] key,
                               input logic [7:0] slot, input logic [31:0] anchor,
                               input logic [31:0] child);
        req_t r;
        r.action       = act;
        r.search_key   = key;
        r.slot         = slot;
        r.anchor_child = anchor;
        r.child_ptr    = child;
        send_request(r);
    endtask

    // Random request shaped by the predicted table: anchors and slots mostly
    // hit live entries so that inserts and shifts really happen, with some
    // misses, wild slots and unused codes mixed in.
    function automatic req_t random_request();
        req_t        r;
        int unsigned n;
        int unsigned pick;
        int unsigned j;
        n = sb.fill;
        j = (n > 0) ? $urandom_range(n - 1) : 0;
        r.search_key   = $urandom();
        r.slot         = 8'($urandom_range(255));
        r.anchor_child = $urandom();
        r.child_ptr    = $urandom();
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            r.action = ACT_INSERT;
            if (n > 0 && $urandom_range(99) < 88)
            begin
                r.anchor_child = sb.kids[j];
                // keep keys roughly in order after the anchor
                if ($urandom_range(1))
                    r.search_key = sb.keys[j] + 32'($urandom_range(255));
            end
            // a repeated child makes the first-match anchor rule matter
            if (n > 0 && $urandom_range(9) == 0)
                r.child_ptr = sb.kids[$urandom_range(n - 1)];
        end
        else if (pick < 55)
        begin
            r.action = ACT_LOOKUP;
            case ($urandom_range(4))
                0: r.search_key = '0;
                1: r.search_key = '1;
                2: r.search_key = $urandom();
                default:
                    if (n > 0)
                        r.search_key = sb.keys[j] + 32'($urandom_range(2)) - 32'd1;
            endcase
        end
        else
        begin
            if (pick < 67)
                r.action = ACT_REMOVE;
            else if (pick < 75)
                r.action = ACT_SET_KEY;
            else if (pick < 82)
                r.action = ACT_SET_CHILD;
            else if (pick < 95)
                r.action = ACT_READ;
            else if (pick < 98)
                r.action = ACT_CLEAR;
            else
                r.action = ACT_UNUSED;
            if (n > 0 && $urandom_range(99) < 85)
                r.slot = 8'(j);
        end
        return r;
    endfunction

    task automatic random_phase(input int unsigned count);
        repeat (count)
            send_request(random_request());
    endtask

    // Fills the node to capacity in key order, pushes on the full table, then
    // empties it again. Each insert goes after the current last entry.
    task automatic fill_to_capacity();
        logic [31:0] anchor;
        int unsigned i;
        send_fields(ACT_CLEAR, '0, '0, '0, '0);
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            anchor = (sb.fill > 0) ? sb.kids[sb.fill - 1] : $urandom();
            send_fields(ACT_INSERT, {8'(i), 24'($urandom())}, '0, anchor, $urandom());
        end
        // full is flagged ahead of the anchor search, good anchor or not
        send_fields(ACT_INSERT, $urandom(), '0, sb.kids[0], $urandom());
        send_fields(ACT_INSERT, $urandom(), '0, $urandom(), $urandom());
        send_fields(ACT_LOOKUP, '1, '0, '0, '0);
        send_fields(ACT_LOOKUP, '0, '0, '0, '0);
        send_fields(ACT_LOOKUP, $urandom(), '0, '0, '0);
        send_fields(ACT_READ, '0, 8'd255, '0, '0);
        send_fields(ACT_REMOVE, '0, 8'd0, '0, '0);
        send_fields(ACT_INSERT, '1, '0, sb.kids[TABLE_DEPTH - 2], '1);
        send_fields(ACT_READ, '0, 8'd255, '0, '0);
        send_fields(ACT_LOOKUP, '1, '0, '0, '0);
        send_fields(ACT_CLEAR, '0, '0, '0, '0);
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lookup, read, remove, set_key and set_child on an empty table first, then a small table
        // with a repeated child, extreme keys and slots, and the unused code.
        send_fields(ACT_LOOKUP,    32'd5, 8'd0, '0, '0);
        send_fields(ACT_READ,      '0, 8'd0, '0, '0);
        send_fields(ACT_REMOVE,    '0, 8'd255, '0, '0);
        send_fields(ACT_SET_KEY,   '1, 8'd0, '0, '0);
        send_fields(ACT_SET_CHILD, '0, 8'd0, '0, '1);
        // empty table takes the pair whatever the anchor says
        send_fields(ACT_INSERT,    32'd100, '0, '1, 32'h10);
        send_fields(ACT_INSERT,    32'd0, '0, 32'hDEAD, 32'h20);
        send_fields(ACT_INSERT,    32'd200, '0, 32'h10, 32'h20);
        send_fields(ACT_INSERT,    32'd150, '0, 32'h10, 32'h10);
        // two entries now hold child 0x10: the first one wins
        send_fields(ACT_INSERT,    32'd160, '0, 32'h10, 32'h30);
        send_fields(ACT_INSERT,    32'hFFFF_FFFE, '0, 32'h20, '1);
        send_fields(ACT_INSERT,    32'd0, '0, '1, '0);
        send_fields(ACT_LOOKUP,    32'd0, '0, '0, '0);
        // search key is all ones, so every key is below: the last child comes back
        send_fields(ACT_LOOKUP,    '1, '0, '0, '0);
        send_fields(ACT_LOOKUP,    32'd155, '0, '0, '0);
        send_fields(ACT_READ,      '0, 8'd4, '0, '0);
        send_fields(ACT_READ,      '0, 8'd6, '0, '0);
        send_fields(ACT_READ,      '0, 8'd255, '0, '0);
        send_fields(ACT_SET_KEY,   '1, 8'd0, '0, '0);
        send_fields(ACT_SET_CHILD, '0, 8'd5, '0, 32'hAAAA_5555);
        send_fields(ACT_REMOVE,    '0, 8'd0, '0, '0);
        send_fields(ACT_REMOVE,    '0, 8'd4, '0, '0);
        send_fields(ACT_UNUSED,    '1, 8'd255, '1, '1);
        send_fields(ACT_CLEAR,     '0, '0, '0, '0);
        send_fields(ACT_LOOKUP,    '0, '0, '0, '0);

        // No idling, with one long receiver hold-off while requests keep coming
        hold_kick = 1'b1;
        random_phase(RAND_PER_PHASE);
        fill_to_capacity();

        send_idle_pct = 82;
        stall_pct     = 0;
        random_phase(RAND_PER_PHASE);

        send_idle_pct = 0;
        stall_pct     = 82;
        random_phase(RAND_PER_PHASE);

        send_idle_pct = 36;
        stall_pct     = 36;
        random_phase(RAND_PER_PHASE);

        req_valid <= 1'b0;
        while (sb.awaited_q.size() != 0)
            @(posedge clk);
        // let any stray response show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests, %0d responses checked, table peaked at %0d of %0d",
                 sb.accepted, sb.checked, sb.peak_fill, TABLE_DEPTH);
        $display("Statuses: ok %0d, range %0d, anchor %0d, full %0d, empty %0d",
                 sb.status_seen[STS_OK], sb.status_seen[STS_RANGE],
                 sb.status_seen[STS_ANCHOR], sb.status_seen[STS_FULL],
                 sb.status_seen[STS_EMPTY]);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
